FILE: hw/rtl/clf_pkg.sv
// ----------------------------------------------------------------------------
// clf_pkg
// shared types, constants and helpers of the camera line framer
// ----------------------------------------------------------------------------
package clf_pkg;

   localparam int ROW_CNT_BITS   = 11;
   localparam int RPF_BITS       = 11;
   localparam int FLIMIT_BITS    = 8;
   localparam int CMP_BITS       = (ROW_CNT_BITS > RPF_BITS) ? ROW_CNT_BITS : RPF_BITS;
   localparam int CSR_IDX_BITS   = 1;
   localparam int CSR_DATA_BITS  = 11;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;
   localparam int QUEUE_CNT_BITS = 3;
   localparam int STEP_BITS      = 3;

   localparam logic [RPF_BITS-1:0]    RPF_RESET    = 11'd480;
   localparam logic [FLIMIT_BITS-1:0] FLIMIT_RESET = 8'd1;

   localparam logic [7:0] HDR_SYNC  = 8'hFF;
   localparam logic [7:0] HDR_FRAME = 8'h87;
   localparam logic [7:0] HDR_ROW   = 8'h11;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_ROWS_PER_FRAME = 1'b0,
      CSR_FRAME_LIMIT    = 1'b1
   } csr_idx_type;

   typedef enum logic [1:0] {
      CMD_FRAME = 2'd0,
      CMD_PIXEL = 2'd1,
      CMD_ROW   = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } push_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } head_type;

   // index of the final byte of a burst
   function automatic logic [STEP_BITS-1:0] cmd_last_step(input cmd_kind_type kind);
      logic [STEP_BITS-1:0] res;
      case (kind)
         CMD_FRAME: res = STEP_BITS'(4);
         CMD_ROW:   res = STEP_BITS'(2);
         CMD_PIXEL: res = STEP_BITS'(0);
         default:   res = STEP_BITS'(0);
      endcase
      return res;
   endfunction

   // byte of a burst at a given step
   function automatic logic [7:0] cmd_byte(input cmd_type cmd,
                                           input logic [STEP_BITS-1:0] step);
      logic [7:0] res;
      res = cmd.data;
      case (cmd.kind)
         CMD_FRAME: begin
            case (step)
               STEP_BITS'(0): res = HDR_SYNC;
               STEP_BITS'(1): res = HDR_FRAME;
               STEP_BITS'(2): res = HDR_SYNC;
               STEP_BITS'(3): res = HDR_ROW;
               default:       res = cmd.data;
            endcase
         end
         CMD_ROW: begin
            case (step)
               STEP_BITS'(0): res = HDR_SYNC;
               STEP_BITS'(1): res = HDR_ROW;
               default:       res = cmd.data;
            endcase
         end
         default: res = cmd.data;
      endcase
      return res;
   endfunction

endpackage

FILE: hw/rtl/clf_if.sv
// ----------------------------------------------------------------------------
// clf channel interfaces
// valid/ready channels for samples, framed bytes and register writes
// ----------------------------------------------------------------------------
interface clf_req_if;
   logic       valid;
   logic       ready;
   logic       vsync_level;
   logic       href_level;
   logic [7:0] pixel_byte;

   modport source (output valid, output vsync_level, output href_level,
                   output pixel_byte, input ready);
   modport sink   (input valid, input vsync_level, input href_level,
                   input pixel_byte, output ready);
endinterface

interface clf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;

   modport source (output valid, output out_byte, output last_of_run, input ready);
   modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

interface clf_csr_if import clf_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [CSR_IDX_BITS-1:0]  index;
   logic [CSR_DATA_BITS-1:0] wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

FILE: hw/rtl/clf_front.sv
// ----------------------------------------------------------------------------
// clf_front
// sample intake: frame/row tracking, registers and burst command issue
// ----------------------------------------------------------------------------
module clf_front import clf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   clf_req_if.sink  req_bus,
   clf_csr_if.sink  csr_bus,
   input  logic     queue_full,
   output push_type push
);

   logic [RPF_BITS-1:0]     rpf_ff, rpf_in;
   logic [FLIMIT_BITS-1:0]  flimit_ff, flimit_in;
   logic                    in_frame_ff, in_frame_in;
   logic [ROW_CNT_BITS-1:0] row_ff, row_in;
   logic [FLIMIT_BITS-1:0]  frames_ff, frames_in;
   logic                    href_prev_ff, href_prev_in;
   logic [ROW_CNT_BITS-1:0] row_next;
   logic                    stopped;
   logic                    take;

   assign req_bus.ready = !queue_full;
   assign csr_bus.ready = 1'b1;
   assign take          = req_bus.valid && !queue_full;
   assign stopped       = frames_ff >= flimit_ff;
   assign row_next      = row_ff + ROW_CNT_BITS'(1);

   always_comb begin
      rpf_in    = rpf_ff;
      flimit_in = flimit_ff;
      if (csr_bus.valid) begin
         case (csr_idx_type'(csr_bus.index))
            CSR_ROWS_PER_FRAME: rpf_in    = csr_bus.wdata[RPF_BITS-1:0];
            CSR_FRAME_LIMIT:    flimit_in = csr_bus.wdata[FLIMIT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      in_frame_in   = in_frame_ff;
      row_in        = row_ff;
      frames_in     = frames_ff;
      href_prev_in  = href_prev_ff;
      push.valid    = 1'b0;
      push.cmd.kind = CMD_PIXEL;
      push.cmd.data = req_bus.pixel_byte;
      if (take && !stopped) begin
         href_prev_in = req_bus.href_level;
         if (!in_frame_ff) begin
            if (req_bus.vsync_level) begin
               in_frame_in   = 1'b1;
               row_in        = '0;
               push.valid    = 1'b1;
               push.cmd.kind = CMD_FRAME;
               push.cmd.data = 8'h00;
            end
         end else if (req_bus.href_level) begin
            push.valid = 1'b1;
         end else if (href_prev_ff) begin
            row_in = row_next;
            if (CMP_BITS'(row_next) == CMP_BITS'(rpf_ff)) begin
               frames_in   = frames_ff + FLIMIT_BITS'(1);
               in_frame_in = 1'b0;
            end else begin
               push.valid    = 1'b1;
               push.cmd.kind = CMD_ROW;
               push.cmd.data = row_next[7:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rpf_ff       <= RPF_RESET;
         flimit_ff    <= FLIMIT_RESET;
         in_frame_ff  <= 1'b0;
         row_ff       <= '0;
         frames_ff    <= '0;
         href_prev_ff <= 1'b0;
      end else begin
         rpf_ff       <= rpf_in;
         flimit_ff    <= flimit_in;
         in_frame_ff  <= in_frame_in;
         row_ff       <= row_in;
         frames_ff    <= frames_in;
         href_prev_ff <= href_prev_in;
      end
   end

endmodule

FILE: hw/rtl/clf_queue.sv
// ----------------------------------------------------------------------------
// clf_queue
// small command queue between intake and byte emitter
// ----------------------------------------------------------------------------
module clf_queue import clf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   input  logic     pop,
   output logic     full,
   output head_type head
);

   cmd_type                   mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                      do_push, do_pop;

   assign full       = count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH);
   assign head.valid = count_ff != '0;
   assign head.cmd   = mem_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: hw/rtl/clf_back.sv
// ----------------------------------------------------------------------------
// clf_back
// byte emitter: expands one command into its header, row or pixel bytes
// ----------------------------------------------------------------------------
module clf_back import clf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  head_type head,
   output logic     pop,
   clf_rsp_if.source rsp_bus
);

   cmd_type              cur_ff, cur_in;
   logic                 busy_ff, busy_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 last;
   logic                 xfer;

   assign last                = step_ff == cmd_last_step(cur_ff.kind);
   assign xfer                = busy_ff && rsp_bus.ready;
   assign rsp_bus.valid       = busy_ff;
   assign rsp_bus.out_byte    = cmd_byte(cur_ff, step_ff);
   assign rsp_bus.last_of_run = last;
   assign pop                 = !busy_ff || (xfer && last);

   always_comb begin
      cur_in  = cur_ff;
      busy_in = busy_ff;
      step_in = step_ff;
      if (pop) begin
         cur_in  = head.cmd;
         busy_in = head.valid;
         step_in = '0;
      end else if (xfer) begin
         step_in = step_ff + STEP_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

endmodule

FILE: hw/rtl/camera_line_framer_unit.sv
// ----------------------------------------------------------------------------
// camera_line_framer_unit
// frames parallel camera samples into a header/row/pixel byte stream
// ----------------------------------------------------------------------------
// req_bus: one pixel-clock sample per transfer (vsync, href, pixel byte).
// rsp_bus: framed bytes; last_of_run marks the final byte of one sample.
// csr_bus: register writes, index 0 rows_per_frame, 1 frame_limit; always
//   ready, write only while no bytes are pending.
// a sample is taken per req transfer; its first byte appears on rsp_bus once the
// command is registered in the queue and then in the emitter (intake, 4-entry command queue, emitter).
// a pixel sample gives 1 byte, a row start 3, a frame start 5; the emitter
// sends one byte per cycle while rsp_bus is ready, so pixels run at one sample
// per cycle and header bursts are absorbed by the queue during blanking.
// samples that give no byte are still accepted by the intake.
// reset clears frame state, counters and the queue, and loads the register
// defaults (480 rows, 1 frame).
// when the receiver stalls, the current byte holds; the queue fills and
// req_bus.ready drops once four commands are waiting.
// ----------------------------------------------------------------------------
module camera_line_framer_unit import clf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   clf_req_if.sink   req_bus,
   clf_rsp_if.source rsp_bus,
   clf_csr_if.sink   csr_bus
);

   push_type push;
   head_type head;
   logic     queue_full;
   logic     pop;

   clf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .csr_bus    (csr_bus),
      .queue_full (queue_full),
      .push       (push)
   );

   clf_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .head  (head)
   );

   clf_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule

FILE: hw/rtl/clf_checker.sv
// ----------------------------------------------------------------------------
// clf_checker
// port-level checks of the camera line framer, bound to the top level
// ----------------------------------------------------------------------------
module clf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last_of_run
);

   // stalled byte holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last_of_run))
      else $error("rsp byte changed while stalled");

   // a burst continues without gaps
   a_burst_cont: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_run |=> rsp_valid)
      else $error("burst broken before its last byte");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("req not ready right after reset");

endmodule

bind camera_line_framer_unit clf_checker u_clf_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_out_byte    (rsp_bus.out_byte),
   .rsp_last_of_run (rsp_bus.last_of_run)
);

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// checks the camera line framer against a built-in byte stream predictor
// ----------------------------------------------------------------------------
// directed tests cover idle href, frame start, pixels, row headers, frame end,
// stopping at the frame limit and a zero row limit; a random part then sends
// well-formed frames with noise under changing register settings, random
// gaps on both channels and one long receiver hold-off
// ----------------------------------------------------------------------------
module tb import clf_pkg::*; ;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } framed_byte_type;

   logic clock;
   logic reset;

   clf_req_if req_bus ();
   clf_rsp_if rsp_bus ();
   clf_csr_if csr_bus ();

   camera_line_framer_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // predictor state and register copies
   logic [RPF_BITS-1:0]     cfg_rows;
   logic [FLIMIT_BITS-1:0]  cfg_frame_limit;
   logic                    in_frame;
   logic [ROW_CNT_BITS-1:0] pred_row;
   logic [7:0]              frames_done;
   logic                    href_prev;

   framed_byte_type pending_bytes[$];
   int              mismatches;
   int              sent_samples;
   bit              no_idle;
   bit              hold_request;
   int              hold_len;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic int pick_gap();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void push_byte(logic [7:0] data, logic last);
      framed_byte_type b;
      b.data = data;
      b.last = last;
      pending_bytes.push_back(b);
   endfunction

   // returns 0 when the sample is ignored because the frame limit was reached
   function automatic bit predict_framing(logic vsync, logic href, logic [7:0] pixel);
      if (frames_done >= cfg_frame_limit) return 1'b0;
      if (!in_frame) begin
         if (vsync) begin
            in_frame = 1'b1;
            pred_row = '0;
            push_byte(HDR_SYNC, 1'b0);
            push_byte(HDR_FRAME, 1'b0);
            push_byte(HDR_SYNC, 1'b0);
            push_byte(HDR_ROW, 1'b0);
            push_byte(pred_row[7:0], 1'b1);
         end
      end else if (href) begin
         push_byte(pixel, 1'b1);
      end else if (href_prev) begin
         pred_row = pred_row + ROW_CNT_BITS'(1);
         if (pred_row == cfg_rows) begin
            frames_done = frames_done + 8'd1;
            in_frame    = 1'b0;
         end else begin
            push_byte(HDR_SYNC, 1'b0);
            push_byte(HDR_ROW, 1'b0);
            push_byte(pred_row[7:0], 1'b1);
         end
      end
      href_prev = href;
      return 1'b1;
   endfunction

   function automatic void note_mismatch(string what, framed_byte_type want);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %0s: expected %h last %0d, got %h last %0d", $realtime, what,
                  want.data, want.last, rsp_bus.out_byte, rsp_bus.last_of_run);
   endfunction

   // result checker
   always @(posedge clock) begin
      framed_byte_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_bytes.size() == 0) begin
            want = '0;
            note_mismatch("byte with none expected", want);
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_bus.out_byte !== want.data || rsp_bus.last_of_run !== want.last)
               note_mismatch("byte mismatch", want);
         end
      end
   end

   // receiver back-pressure
   initial begin
      int stall;
      stall = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            stall        = hold_len;
            hold_request = 1'b0;
         end else if (stall == 0 && !no_idle && $urandom_range(0, 99) < 20) begin
            stall = pick_gap();
         end
         if (stall > 0) begin
            rsp_bus.ready = 1'b0;
            stall--;
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   task automatic send_sample(logic vsync, logic href, logic [7:0] pixel);
      int gap;
      gap = (no_idle || $urandom_range(0, 99) < 55) ? 0 : pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid       = 1'b1;
      req_bus.vsync_level = vsync;
      req_bus.href_level  = href;
      req_bus.pixel_byte  = pixel;
      do @(posedge clock); while (!req_bus.ready);
      void'(predict_framing(vsync, href, pixel));
      sent_samples++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.wdata = value;
      do @(posedge clock); while (!csr_bus.ready);
      if (idx == CSR_ROWS_PER_FRAME) cfg_rows = value[RPF_BITS-1:0];
      else cfg_frame_limit = value[FLIMIT_BITS-1:0];
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // reset registers: 480 rows, one frame
   task automatic test_defaults();
      send_sample(1'b0, 1'b1, 8'h00);
      send_sample(1'b0, 1'b0, 8'hFF);
      send_sample(1'b1, 1'b1, 8'h5A);
      send_sample(1'b0, 1'b1, 8'hFF);
      send_sample(1'b1, 1'b1, 8'h00);
      send_sample(1'b0, 1'b0, 8'h3C);
      send_sample(1'b1, 1'b0, 8'h00);
      send_sample(1'b0, 1'b1, 8'h81);
      drain();
   endtask

   // frame end at the row limit, then everything is ignored
   task automatic test_stop();
      write_reg(CSR_ROWS_PER_FRAME, 11'd2);
      send_sample(1'b0, 1'b0, 8'h00);
      send_sample(1'b1, 1'b0, 8'h7E);
      send_sample(1'b0, 1'b1, 8'hC3);
      drain();
      write_reg(CSR_FRAME_LIMIT, 11'd0);
      send_sample(1'b1, 1'b1, 8'hFF);
      drain();
   endtask

   // largest row limit, frame limit with upper data bits set
   task automatic test_limits();
      write_reg(CSR_FRAME_LIMIT, 11'h702);
      write_reg(CSR_ROWS_PER_FRAME, 11'd2047);
      send_sample(1'b1, 1'b0, 8'h00);
      send_sample(1'b0, 1'b1, 8'hAA);
      send_sample(1'b0, 1'b0, 8'h55);
      send_sample(1'b0, 1'b1, 8'h01);
      send_sample(1'b0, 1'b0, 8'h00);
      drain();
      write_reg(CSR_ROWS_PER_FRAME, 11'd3);
      send_sample(1'b0, 1'b1, 8'h80);
      send_sample(1'b0, 1'b0, 8'h00);
      send_sample(1'b1, 1'b1, 8'hFF);
      drain();
   endtask

   // row limit zero: the frame keeps running past every row counted here
   task automatic test_row_wrap();
      write_reg(CSR_FRAME_LIMIT, 11'd3);
      write_reg(CSR_ROWS_PER_FRAME, 11'd0);
      send_sample(1'b1, 1'b0, 8'($urandom));
      repeat (12) begin
         send_sample(1'($urandom), 1'b1, 8'($urandom));
         send_sample(1'($urandom), 1'b0, 8'($urandom));
      end
      drain();
   endtask

   task automatic test_random();
      int phase;
      int rows;
      int limit;
      int frames;
      phase = 0;
      while (sent_samples < 320) begin
         drain();
         rows = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 4);
         if (phase == 2) limit = 255;
         else if (phase % 7 == 5) limit = frames_done;
         else limit = frames_done + $urandom_range(1, 3);
         if (limit > 255) limit = 255;
         write_reg(CSR_ROWS_PER_FRAME, 11'(rows));
         write_reg(CSR_FRAME_LIMIT, {3'($urandom), 8'(limit)});
         no_idle = ($urandom_range(0, 3) == 0);
         if (phase == 1) begin
            no_idle      = 1'b1;
            hold_len     = 150;
            hold_request = 1'b1;
         end
         frames = $urandom_range(1, 3);
         repeat (frames) begin
            repeat ($urandom_range(0, 2)) send_sample(1'b0, 1'($urandom), 8'($urandom));
            repeat ($urandom_range(1, 3)) send_sample(1'b1, 1'b0, 8'($urandom));
            repeat (rows) begin
               repeat ($urandom_range(1, 6))
                  send_sample($urandom_range(0, 9) == 0, 1'b1, 8'($urandom));
               repeat ($urandom_range(1, 3))
                  send_sample($urandom_range(0, 9) == 0, 1'b0, 8'($urandom));
               if ($urandom_range(0, 9) == 0)
                  send_sample(1'($urandom), 1'($urandom), 8'($urandom));
            end
         end
         phase++;
      end
      no_idle = 1'b0;
   endtask

   initial begin
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.vsync_level = 1'b0;
      req_bus.href_level  = 1'b0;
      req_bus.pixel_byte  = 8'h00;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = CSR_ROWS_PER_FRAME;
      csr_bus.wdata       = '0;
      cfg_rows            = RPF_RESET;
      cfg_frame_limit     = FLIMIT_RESET;
      in_frame            = 1'b0;
      pred_row            = '0;
      frames_done         = 8'd0;
      href_prev           = 1'b0;
      mismatches          = 0;
      sent_samples        = 0;
      no_idle             = 1'b0;
      hold_request        = 1'b0;
      hold_len            = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_defaults();
      test_stop();
      test_limits();
      test_row_wrap();
      test_random();
      drain();

      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/clf_pkg.sv
hw/rtl/clf_if.sv
hw/rtl/clf_front.sv
hw/rtl/clf_queue.sv
hw/rtl/clf_back.sv
hw/rtl/camera_line_framer_unit.sv
hw/rtl/clf_checker.sv
tb/sv/tb.sv
